### src/kmcd_pkg.sv
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared widths and reset values for the key matrix counter debounce block.
// ----------------------------------------------------------------------------
package kmcd_pkg;

  // Row lines per column. The sample and result fields are fixed at this width.
  localparam int Rows = 4;

  // Width of each per-key debounce counter.
  localparam int CntW = 8;

  // Width of the column index result field.
  localparam int ColIdxW = 5;

  // Default number of scanned columns.
  localparam int NumColumnsDef = 18;

  // Reset value of the debounce threshold register.
  localparam logic [CntW-1:0] ThreshReset = 8'd8;

endpackage

### src/kmcd_key_update.sv
// ----------------------------------------------------------------------------
// kmcd_key_update
// Per-key counter debounce update for one column of row samples.
// ----------------------------------------------------------------------------
module kmcd_key_update (
  input  logic [kmcd_pkg::Rows-1:0] sample_i,
  input  logic [kmcd_pkg::Rows-1:0] held_i,
  input  logic [kmcd_pkg::CntW-1:0] cnt_i [kmcd_pkg::Rows],
  input  logic [kmcd_pkg::CntW-1:0] threshold_i,
  output logic [kmcd_pkg::Rows-1:0] held_o,
  output logic [kmcd_pkg::CntW-1:0] cnt_o [kmcd_pkg::Rows],
  output logic [kmcd_pkg::Rows-1:0] flips_o
);

  for (genvar r = 0; r < kmcd_pkg::Rows; r++) begin : g_key
    logic [kmcd_pkg::CntW:0] inc;
    logic                    hit;

    // The extra bit holds the carry of the increment, so the extra bit never overflows.
    assign inc = {1'b0, cnt_i[r]} + {{kmcd_pkg::CntW{1'b0}}, 1'b1};
    assign hit = (sample_i[r] != held_i[r]) && (inc >= {1'b0, threshold_i});

    always_comb begin
      if (sample_i[r] == held_i[r]) begin
        cnt_o[r] = '0;
      end else if (hit) begin
        cnt_o[r] = '0;
      end else begin
        cnt_o[r] = inc[kmcd_pkg::CntW-1:0];
      end
    end

    assign flips_o[r] = hit;
    assign held_o[r]  = held_i[r] ^ hit;
  end

endmodule

### src/kmcd_key_store.sv
// ----------------------------------------------------------------------------
// kmcd_key_store
// Debounced bits and debounce counters for every key, one entry per column.
// ----------------------------------------------------------------------------
module kmcd_key_store #(
  parameter int NUM_COLUMNS = kmcd_pkg::NumColumnsDef,
  parameter int ColW        = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ColW-1:0]           col_i,
  input  logic                      wr_en_i,
  input  logic [kmcd_pkg::Rows-1:0] held_i,
  input  logic [kmcd_pkg::CntW-1:0] cnt_i [kmcd_pkg::Rows],
  output logic [kmcd_pkg::Rows-1:0] held_o,
  output logic [kmcd_pkg::CntW-1:0] cnt_o [kmcd_pkg::Rows]
);

  logic [kmcd_pkg::Rows-1:0] held_q [NUM_COLUMNS];
  logic [kmcd_pkg::CntW-1:0] cnt_q  [NUM_COLUMNS][kmcd_pkg::Rows];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        held_q[c] <= '0;
        for (int r = 0; r < kmcd_pkg::Rows; r++) begin
          cnt_q[c][r] <= '0;
        end
      end
    end else if (wr_en_i) begin
      held_q[col_i] <= held_i;
      for (int r = 0; r < kmcd_pkg::Rows; r++) begin
        cnt_q[col_i][r] <= cnt_i[r];
      end
    end
  end

  assign held_o = held_q[col_i];

  for (genvar r = 0; r < kmcd_pkg::Rows; r++) begin : g_rd
    assign cnt_o[r] = cnt_q[col_i][r];
  end

endmodule

### src/key_matrix_counter_debounce.sv
// ----------------------------------------------------------------------------
// key_matrix_counter_debounce
// Counter debounce of a scanned key matrix, one column sample per transaction.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   row_sample_i
//   output   out        out_valid_o / out_stall_i column_index_o, debounced_bits_o,
//                                                 changed_bits_o, last_column_o,
//                                                 frame_changed_o
//   config   in         cfg_wen_i                 cfg_wdata_i
//
// One transaction per cycle is sustained while out_stall_i is low. A result passes
// through the input register, then the result register, before it is valid at the
// output; a stall at the output can hold it between the two.
// The per-key compare and counter step lie between those registers.
// Reset clears all key state and the column pointer and sets the threshold to 8.
// A stall at the output holds the result register; the input register still
// accepts one transaction behind it before in_stall_o rises.
// ----------------------------------------------------------------------------
module key_matrix_counter_debounce #(
  parameter int NUM_COLUMNS = kmcd_pkg::NumColumnsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wen_i,
  input  logic [kmcd_pkg::CntW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kmcd_pkg::Rows-1:0]    row_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kmcd_pkg::ColIdxW-1:0] column_index_o,
  output logic [kmcd_pkg::Rows-1:0]    debounced_bits_o,
  output logic [kmcd_pkg::Rows-1:0]    changed_bits_o,
  output logic                         last_column_o,
  output logic                         frame_changed_o
);

  localparam int ColW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [ColW-1:0] LastCol = ColW'(NUM_COLUMNS - 1);

  logic [kmcd_pkg::CntW-1:0]    thresh_q;
  logic [ColW-1:0]              col_ptr_q;
  logic                         s1_valid_q;
  logic [kmcd_pkg::Rows-1:0]    s1_sample_q;
  logic [ColW-1:0]              s1_col_q;
  logic                         frame_seen_q;
  logic                         out_valid_q;
  logic [kmcd_pkg::ColIdxW-1:0] col_idx_q;
  logic [kmcd_pkg::Rows-1:0]    deb_q;
  logic [kmcd_pkg::Rows-1:0]    chg_q;
  logic                         last_q;
  logic                         frame_chg_q;

  logic                         accept_in;
  logic                         s2_ready;
  logic                         advance;
  logic                         is_last;
  logic [kmcd_pkg::Rows-1:0]    held_rd;
  logic [kmcd_pkg::CntW-1:0]    cnt_rd [kmcd_pkg::Rows];
  logic [kmcd_pkg::Rows-1:0]    held_wr;
  logic [kmcd_pkg::CntW-1:0]    cnt_wr [kmcd_pkg::Rows];
  logic [kmcd_pkg::Rows-1:0]    flips;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign is_last    = (s1_col_q == LastCol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= kmcd_pkg::ThreshReset;
    end else if (cfg_wen_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // The column is assigned at acceptance; the pointer wraps after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_ptr_q  <= '0;
      s1_valid_q <= 1'b0;
    end else if (accept_in) begin
      col_ptr_q  <= (col_ptr_q == LastCol) ? '0 : col_ptr_q + ColW'(1);
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_sample_q <= row_sample_i;
      s1_col_q    <= col_ptr_q;
    end
  end

  kmcd_key_store #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .ColW        (ColW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .col_i   (s1_col_q),
    .wr_en_i (advance),
    .held_i  (held_wr),
    .cnt_i   (cnt_wr),
    .held_o  (held_rd),
    .cnt_o   (cnt_rd)
  );

  kmcd_key_update u_update (
    .sample_i    (s1_sample_q),
    .held_i      (held_rd),
    .cnt_i       (cnt_rd),
    .threshold_i (thresh_q),
    .held_o      (held_wr),
    .cnt_o       (cnt_wr),
    .flips_o     (flips)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      if (is_last) begin
        frame_seen_q <= 1'b0;
      end else if (|flips) begin
        frame_seen_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      col_idx_q   <= kmcd_pkg::ColIdxW'(s1_col_q);
      deb_q       <= held_wr;
      chg_q       <= flips;
      last_q      <= is_last;
      frame_chg_q <= is_last && (frame_seen_q || (|flips));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign column_index_o   = col_idx_q;
  assign debounced_bits_o = deb_q;
  assign changed_bits_o   = chg_q;
  assign last_column_o    = last_q;
  assign frame_changed_o  = frame_chg_q;

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ptr_q <= LastCol)
    else $error("column pointer beyond last column");

  a_frame_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_column_o |-> !frame_changed_o)
    else $error("frame change flagged on a column that is not the last");

  a_frame_covers_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_column_o && (changed_bits_o != '0) |-> frame_changed_o)
    else $error("flip on last column not reported as frame change");

  a_flip_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !is_last && (flips != '0) |=> frame_seen_q)
    else $error("flip during frame not recorded");
`endif

endmodule
